FILE: design/tgd_pkg.sv
// Shared types and constants for the tap gesture detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package tgd_pkg;

  localparam int THRESH_W  = 15;
  localparam int DUR_W     = 32;
  localparam int ELAPSED_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Item mode codes; the fourth code is a no-op.
  localparam logic [1:0] MODE_UPDATE  = 2'd0;
  localparam logic [1:0] MODE_INITIAL = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_AXIS  = 2'd2;

  typedef enum logic [1:0] {
    PH_WAITING   = 2'd0,
    PH_STARTED   = 2'd1,
    PH_PERFORMED = 2'd2,
    PH_FAILED    = 2'd3
  } phase_t;

  // Control fields carried from the square stage to the state stage.
  typedef struct packed {
    logic [1:0]           mode;
    logic                 scalar_over;
    logic [ELAPSED_W-1:0] elapsed;
  } stage_ctl_t;

endpackage

`default_nettype wire

FILE: design/tgd_square.sv
// First pipeline stage: sample magnitudes, their squares, threshold square
// and the scalar compare. Depends on tgd_pkg.
`default_nettype none

module tgd_square import tgd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic [1:0]                    mode,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_y,
  input  wire logic [ELAPSED_W-1:0]          elapsed,
  input  wire logic [THRESH_W-1:0]           threshold,
  output logic [2*SAMPLE_BITS-1:0]           x_sq,
  output logic [2*SAMPLE_BITS-1:0]           y_sq,
  output logic [2*THRESH_W-1:0]              t_sq,
  output stage_ctl_t                         ctl
);

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  logic [SAMPLE_BITS-1:0] mag_x;
  logic [SAMPLE_BITS-1:0] mag_y;
  logic                   scalar_over;

  // Two's complement magnitude; the most negative value maps to 2^(n-1).
  assign mag_x = sample_x[SAMPLE_BITS-1] ? (~sample_x + 1'b1) : sample_x;
  assign mag_y = sample_y[SAMPLE_BITS-1] ? (~sample_y + 1'b1) : sample_y;

  assign scalar_over = !sample_x[SAMPLE_BITS-1] &&
                       (CMP_W'(mag_x) >= CMP_W'(threshold));

  always_ff @(posedge clk) begin
    if (load) begin
      x_sq            <= SQ_W'(mag_x) * SQ_W'(mag_x);
      y_sq            <= SQ_W'(mag_y) * SQ_W'(mag_y);
      t_sq            <= (2*THRESH_W)'(threshold) * (2*THRESH_W)'(threshold);
      ctl.mode        <= mode;
      ctl.scalar_over <= scalar_over;
      ctl.elapsed     <= elapsed;
    end
  end

endmodule

`default_nettype wire

FILE: design/tgd_fsm.sv
// Second pipeline stage: magnitude compare, tap state machine, hold timer
// and the result register. Depends on tgd_pkg.
`default_nettype none

module tgd_fsm import tgd_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     load,
  input  wire stage_ctl_t               ctl,
  input  wire logic [2*SAMPLE_BITS-1:0] x_sq,
  input  wire logic [2*SAMPLE_BITS-1:0] y_sq,
  input  wire logic [2*THRESH_W-1:0]    t_sq,
  input  wire logic                     two_axis,
  input  wire logic [DUR_W-1:0]         duration,
  output logic [1:0]                    phase,
  output logic                          trigger
);

  localparam int SUM_W = (2*SAMPLE_BITS + 1 > 2*THRESH_W) ? 2*SAMPLE_BITS + 1 : 2*THRESH_W;
  localparam int CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  phase_t               phase_reg;
  phase_t               phase_next;
  logic [TIME_BITS-1:0] hold_time;
  logic [TIME_BITS-1:0] hold_time_next;
  logic [TIME_BITS:0]   hold_sum;
  logic [TIME_BITS-1:0] hold_sat;
  logic [SUM_W-1:0]     mag_sum;
  logic                 over;

  assign mag_sum = SUM_W'(x_sq) + SUM_W'(y_sq);
  assign over    = two_axis ? (mag_sum >= SUM_W'(t_sq)) : ctl.scalar_over;

  // Saturating timer add: carry out pins the count at all ones.
  assign hold_sum = {1'b0, hold_time} + (TIME_BITS+1)'(ctl.elapsed);
  assign hold_sat = hold_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : hold_sum[TIME_BITS-1:0];

  always_comb begin
    phase_next     = phase_reg;
    hold_time_next = hold_time;
    case (ctl.mode)
      MODE_INITIAL: begin
        hold_time_next = '0;
        phase_next     = over ? PH_STARTED : PH_WAITING;
      end
      MODE_UPDATE: begin
        if (phase_reg == PH_WAITING && over) begin
          phase_next = PH_STARTED;
        end else if (phase_reg == PH_STARTED && !over) begin
          phase_next = PH_PERFORMED;
        end
      end
      MODE_TICK: begin
        if (phase_reg == PH_STARTED) begin
          hold_time_next = hold_sat;
          if (CMP_W'(hold_sat) >= CMP_W'(duration)) begin
            phase_next = PH_FAILED;
          end
        end else if (phase_reg == PH_PERFORMED || phase_reg == PH_FAILED) begin
          phase_next     = PH_WAITING;
          hold_time_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg <= PH_WAITING;
      hold_time <= '0;
    end else if (load) begin
      phase_reg <= phase_next;
      hold_time <= hold_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      phase   <= phase_next;
      trigger <= (phase_next == PH_PERFORMED);
    end
  end

  // Waiting is only entered with the timer cleared.
  assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_WAITING |-> hold_time == '0)
    else $error("hold timer nonzero while waiting");

  // State moves only when a transaction passes through this stage.
  assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(phase_reg) && $stable(hold_time))
    else $error("state changed without a transaction");

  // Performed is reached from started only.
  assert property (@(posedge clk) disable iff (rst)
    load && phase_next == PH_PERFORMED && phase_reg != PH_PERFORMED
      |-> phase_reg == PH_STARTED)
    else $error("performed entered from wrong phase");

endmodule

`default_nettype wire

FILE: design/tap_gesture_detector_unit.sv
// Top level of the tap gesture detector: config registers, pipeline valids
// and flow control. Depends on tgd_pkg, tgd_square and tgd_fsm.
// A result passes the square stage register, then the state stage register.
// Throughput: one item per cycle unless the output stalls; the two stages collapse bubbles.
// Reset (rst, synchronous): phase waiting, timer and config registers zero,
// pipeline empty.
`default_nettype none

module tap_gesture_detector_unit import tgd_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [1:0]                    mode,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_y,
  input  wire logic [ELAPSED_W-1:0]          elapsed,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [1:0]                         phase,
  output logic                               trigger
);

  logic [THRESH_W-1:0]      threshold;
  logic [DUR_W-1:0]         duration;
  logic                     two_axis;
  logic                     sq_valid;
  logic                     out_adv;
  logic                     sq_load;
  logic                     fsm_load;
  logic [2*SAMPLE_BITS-1:0] x_sq;
  logic [2*SAMPLE_BITS-1:0] y_sq;
  logic [2*THRESH_W-1:0]    t_sq;
  stage_ctl_t               ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      duration  <= '0;
      two_axis  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
        REG_DURATION:  duration  <= cfg_data[DUR_W-1:0];
        REG_TWO_AXIS:  two_axis  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Output register can take a new result when empty or being drained.
  assign out_adv    = !result_valid || !result_stall;
  assign item_stall = sq_valid && !out_adv;
  assign sq_load    = item_valid && !item_stall;
  assign fsm_load   = sq_valid && out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!sq_valid || out_adv) begin
        sq_valid <= item_valid;
      end
      if (out_adv) begin
        result_valid <= sq_valid;
      end
    end
  end

  tgd_square #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_square (
    .clk       (clk),
    .load      (sq_load),
    .mode      (mode),
    .sample_x  (sample_x),
    .sample_y  (sample_y),
    .elapsed   (elapsed),
    .threshold (threshold),
    .x_sq      (x_sq),
    .y_sq      (y_sq),
    .t_sq      (t_sq),
    .ctl       (ctl)
  );

  tgd_fsm #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_fsm (
    .clk      (clk),
    .rst      (rst),
    .load     (fsm_load),
    .ctl      (ctl),
    .x_sq     (x_sq),
    .y_sq     (y_sq),
    .t_sq     (t_sq),
    .two_axis (two_axis),
    .duration (duration),
    .phase    (phase),
    .trigger  (trigger)
  );

  // Input stalls only when both stages hold a transaction.
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> sq_valid && result_valid && result_stall)
    else $error("input stalled with room in pipeline");

  // A transaction in the first stage reaches the output on the next edge it can.
  assert property (@(posedge clk) disable iff (rst)
    fsm_load |=> result_valid)
    else $error("transaction lost between stages");

  // Trigger is high exactly for performed results.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> trigger == (phase == PH_PERFORMED))
    else $error("trigger disagrees with phase");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for tap_gesture_detector_unit: a queue-fed driver, a
// monitor checking each result against an in-bench tap state predictor.
// Depends on tgd_pkg and the design sources only.

module tb_top;
  import tgd_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam logic [1:0] MODE_NOP = 2'd3;  // unused code, block holds state

  typedef struct packed {
    phase_t ph;
    logic   trig;
  } tap_result_t;

  typedef struct {
    logic [1:0]                 mode;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic [ELAPSED_W-1:0]       el;
    bit                         wait_drain;
  } tap_item_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          item_valid = 1'b0;
  logic                          item_stall;
  logic [1:0]                    mode = '0;
  logic signed [SAMPLE_W-1:0]    sample_x = '0;
  logic signed [SAMPLE_W-1:0]    sample_y = '0;
  logic [ELAPSED_W-1:0]          elapsed = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [1:0]                    phase;
  logic                          trigger;

  tap_gesture_detector_unit #(
    .SAMPLE_BITS(SAMPLE_W),
    .TIME_BITS  (32)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .mode        (mode),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .elapsed     (elapsed),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .phase       (phase),
    .trigger     (trigger)
  );

  always #6 clk = ~clk;

  // Predictor state and its copy of the registers
  phase_t              model_phase = PH_WAITING;
  logic [31:0]         model_hold = '0;
  logic [THRESH_W-1:0] cfg_thresh = '0;
  logic [DUR_W-1:0]    cfg_dur = '0;
  logic                cfg_two_axis = 1'b0;

  tap_item_t   pending_items[$];
  tap_result_t tap_expected[$];
  int          errors = 0;
  int          items_queued = 0;
  bit          drain_next = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  tap_item_t   drv_item;
  tap_result_t drv_result;
  tap_result_t mon_result;
  bit          send_ok;

  function automatic bit control_over(logic signed [SAMPLE_W-1:0] x,
                                      logic signed [SAMPLE_W-1:0] y);
    int ax;
    int ay;
    longint t;
    t = cfg_thresh;
    ax = int'(x);
    ay = int'(y);
    if (!cfg_two_axis) return (ax >= 0) && (longint'(ax) >= t);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    return longint'(ax) * ax + longint'(ay) * ay >= t * t;
  endfunction

  function automatic tap_result_t detect_step(tap_item_t it);
    tap_result_t r;
    logic [32:0] sum;
    case (it.mode)
      MODE_INITIAL: begin
        model_hold  = '0;
        model_phase = control_over(it.x, it.y) ? PH_STARTED : PH_WAITING;
      end
      MODE_UPDATE: begin
        if (model_phase == PH_WAITING && control_over(it.x, it.y))
          model_phase = PH_STARTED;
        else if (model_phase == PH_STARTED && !control_over(it.x, it.y))
          model_phase = PH_PERFORMED;
      end
      MODE_TICK: begin
        if (model_phase == PH_STARTED) begin
          sum = {1'b0, model_hold} + 33'(it.el);
          model_hold = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (model_hold >= cfg_dur) model_phase = PH_FAILED;
        end else if (model_phase == PH_PERFORMED || model_phase == PH_FAILED) begin
          model_phase = PH_WAITING;
          model_hold  = '0;
        end
      end
      default: ;
    endcase
    r.ph   = model_phase;
    r.trig = (model_phase == PH_PERFORMED);
    return r;
  endfunction

  // Driver: predicts on each accepted transaction, then offers the next item
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        drv_item.mode = mode;
        drv_item.x    = sample_x;
        drv_item.y    = sample_y;
        drv_item.el   = elapsed;
        drv_result    = detect_step(drv_item);
        tap_expected.push_back(drv_result);
      end
      if (!item_valid || !item_stall) begin
        send_ok = pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (send_ok && pending_items[0].wait_drain && tap_expected.size() != 0)
          send_ok = 1'b0;
        if (send_ok) begin
          drv_item = pending_items.pop_front();
          mode     <= drv_item.mode;
          sample_x <= drv_item.x;
          sample_y <= drv_item.y;
          elapsed  <= drv_item.el;
        end
        item_valid <= send_ok;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (tap_expected.size() == 0) begin
        $display("%0t unexpected result: expected none, actual phase=%0d trigger=%0d",
                 $time, phase, trigger);
        errors++;
      end else begin
        mon_result = tap_expected.pop_front();
        if (phase !== mon_result.ph) begin
          $display("%0t phase mismatch: expected %0d actual %0d",
                   $time, mon_result.ph, phase);
          errors++;
        end
        if (trigger !== mon_result.trig) begin
          $display("%0t trigger mismatch: expected %0d actual %0d",
                   $time, mon_result.trig, trigger);
          errors++;
        end
      end
    end
  end

  function automatic void queue_item(logic [1:0] m, logic signed [SAMPLE_W-1:0] x,
                                     logic signed [SAMPLE_W-1:0] y,
                                     logic [ELAPSED_W-1:0] el);
    tap_item_t it;
    it.mode       = m;
    it.x          = x;
    it.y          = y;
    it.el         = el;
    it.wait_drain = drain_next;
    drain_next    = 1'b0;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  // Aim a sample above or below the current threshold; some are left random
  function automatic void pick_sample(bit want_over, output logic signed [SAMPLE_W-1:0] x,
                                      output logic signed [SAMPLE_W-1:0] y);
    int unsigned t;
    int unsigned mag;
    int unsigned lim;
    t = cfg_thresh;
    x = SAMPLE_W'($urandom);
    y = SAMPLE_W'($urandom);
    if ($urandom_range(3) == 0) return;
    if (want_over) begin
      case ($urandom_range(2))
        0:       mag = t;
        1:       mag = 32767;
        default: mag = $urandom_range(32767, t);
      endcase
      x = SAMPLE_W'(mag);
      if (cfg_two_axis) begin
        if ($urandom_range(1)) x = -x;
        if ($urandom_range(1)) begin
          y = x;
          x = SAMPLE_W'($urandom);
        end
      end
    end else if (!cfg_two_axis) begin
      if (t == 0 || $urandom_range(3) == 0)
        x = SAMPLE_W'(-int'($urandom_range(32768, 1)));
      else if ($urandom_range(1))
        x = SAMPLE_W'(t - 1);
      else
        x = SAMPLE_W'($urandom_range(t - 1, 0));
    end else begin
      lim = t * 7 / 10;
      x = SAMPLE_W'($urandom_range(lim));
      y = SAMPLE_W'($urandom_range(lim));
      if ($urandom_range(1)) x = -x;
      if ($urandom_range(1)) y = -y;
    end
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return ELAPSED_W'($urandom);
      default: return ELAPSED_W'($urandom_range(700));
    endcase
  endfunction

  // Press, optional hold and ticks, release, then ticks back to waiting
  function automatic void add_tap_sequence();
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    pick_sample($urandom_range(4) != 0, x, y);
    queue_item($urandom_range(5) == 0 ? MODE_UPDATE : MODE_INITIAL, x, y, pick_elapsed());
    repeat ($urandom_range(2)) begin
      pick_sample(1'b1, x, y);
      queue_item(MODE_UPDATE, x, y, pick_elapsed());
    end
    repeat ($urandom_range(3)) queue_item(MODE_TICK, SAMPLE_W'($urandom),
                                          SAMPLE_W'($urandom), pick_elapsed());
    pick_sample(1'b0, x, y);
    queue_item(MODE_UPDATE, x, y, pick_elapsed());
    repeat ($urandom_range(2, 1)) queue_item(MODE_TICK, SAMPLE_W'($urandom),
                                             SAMPLE_W'($urandom), pick_elapsed());
  endfunction

  function automatic void add_noise_item();
    queue_item(2'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
               ELAPSED_W'($urandom));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_THRESHOLD: cfg_thresh   = data[THRESH_W-1:0];
      REG_DURATION:  cfg_dur      = data[DUR_W-1:0];
      REG_TWO_AXIS:  cfg_two_axis = data[0];
      default: ;
    endcase
  endtask

  // Sampled away from the rising edge so driver and monitor updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || item_valid || tap_expected.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_phase(logic [CFG_DATA_W-1:0] thr_word, logic [CFG_DATA_W-1:0] dur,
                             logic [CFG_DATA_W-1:0] axis_word, int send_pct, int recv_pct);
    wait_idle();
    write_reg(REG_THRESHOLD, thr_word);
    write_reg(REG_DURATION, dur);
    write_reg(REG_TWO_AXIS, axis_word);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int target;
    int send_pct;
    int recv_pct;
    logic [31:0] thr;
    logic [31:0] dur;
    logic axis;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset config: zero threshold, zero duration, scalar
    queue_item(MODE_UPDATE, -16'sd32768, '0, '0);  // negative never over
    queue_item(MODE_UPDATE, '0, '0, '0);
    queue_item(MODE_TICK, '0, '0, '0);              // zero duration fails at once
    queue_item(MODE_UPDATE, -16'sd1, '0, '0);
    queue_item(MODE_TICK, '0, '0, '1);
    queue_item(MODE_NOP, -16'sd1, -16'sd1, '1);
    queue_item(MODE_INITIAL, 16'sd32767, '0, '0);
    queue_item(MODE_UPDATE, 16'sd32767, '0, '0);    // cannot release at zero threshold
    queue_item(MODE_INITIAL, -16'sd32768, '0, '0);

    // Upper data bits set: register keeps only its own width
    start_phase(32'hFFFF_FFFF, 32'd100, 32'hFFFF_FFFF, 0, 0);
    queue_item(MODE_INITIAL, -16'sd32768, '0, '0);
    queue_item(MODE_TICK, '0, '0, '1);
    queue_item(MODE_TICK, '0, '0, '0);
    queue_item(MODE_UPDATE, 16'sd20000, 16'sd20000, '0);
    queue_item(MODE_UPDATE, -16'sd23170, 16'sd23170, '0);
    queue_item(MODE_UPDATE, '0, -16'sd32768, '0);
    queue_item(MODE_UPDATE, 16'sd1, 16'sd1, '0);
    queue_item(MODE_UPDATE, 16'sd32767, '0, '0);
    queue_item(MODE_TICK, '0, '0, 16'd5);
    queue_item(MODE_NOP, '0, '0, '0);

    // Threshold edge in scalar mode, then a long hold with large ticks
    start_phase(32'd1000, 32'hFFFF_FFFF, 32'd0, 0, 0);
    queue_item(MODE_INITIAL, 16'sd999, '0, '0);
    queue_item(MODE_UPDATE, 16'sd1000, '0, '0);
    queue_item(MODE_INITIAL, 16'sd1000, '0, '0);
    queue_item(MODE_TICK, '0, '0, 16'd1);
    repeat (20) queue_item(MODE_TICK, '0, '0, '1);
    queue_item(MODE_UPDATE, '0, '0, '0);
    queue_item(MODE_TICK, '0, '0, '0);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 71; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 71; end
        default: begin send_pct = 28; recv_pct = 28; end
      endcase
      case (p)
        2:       thr = 32'd0;
        5:       thr = 32'd32767;
        default: thr = $urandom_range(32767, 1);
      endcase
      case (p)
        3:       dur = 32'd0;
        6:       dur = 32'hFFFF_FFFF;
        4:       dur = $urandom;
        default: dur = $urandom_range(3000);
      endcase
      axis = (p < 4) ? p[0] : ~p[0];
      start_phase(($urandom & ~32'h7FFF) | thr, dur, ($urandom & ~32'h1) | axis,
                  send_pct, recv_pct);
      target = items_queued + 100;
      while (items_queued < target)
        if ($urandom_range(9) < 8) add_tap_sequence();
        else add_noise_item();
      // sender holds off until the pipeline has fully drained
      if (p % 2 == 1) drain_next = 1'b1;
      target = items_queued + 100;
      while (items_queued < target)
        if ($urandom_range(9) < 8) add_tap_sequence();
        else add_noise_item();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
